// ===== hdl/aczq_pkg.sv =====
// Shared types and constants for the AC zero-crossing qualifier.
`timescale 1ns / 1ps
`default_nettype none

package aczq_pkg;

    typedef logic [7:0] count_t;

    typedef enum logic [1:0] {
        STATUS_IDLE  = 2'd0,
        STATUS_CAL   = 2'd1,
        STATUS_READY = 2'd2,
        STATUS_ERROR = 2'd3
    } status_t;

    typedef enum logic {
        MODE_TICK  = 1'b0,
        MODE_BEGIN = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        REG_MIN_STABLE    = 2'd0,
        REG_MAX_STABLE    = 2'd1,
        REG_DELAY_RISING  = 2'd2,
        REG_DELAY_FALLING = 2'd3
    } reg_index_t;

    localparam int     BEGIN_WIDTH       = 5;
    localparam count_t COUNT_FULL        = 8'd255;
    localparam count_t ELAPSED_SAT       = 8'd254;
    localparam count_t MIN_STABLE_RESET  = 8'd48;
    localparam count_t MAX_STABLE_RESET  = 8'd51;

endpackage

`default_nettype wire

// ===== hdl/aczq_in_if.sv =====
// Input channel: a sampling tick or a begin command with its preloaded window.
`timescale 1ns / 1ps
`default_nettype none

interface aczq_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 mode;
    logic                                 sample_bit;
    logic [aczq_pkg::BEGIN_WIDTH-1:0]     begin_window;

    modport source (output valid, output mode, output sample_bit, output begin_window,
                    input ready);
    modport sink   (input valid, input mode, input sample_bit, input begin_window,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/aczq_out_if.sv =====
// Result channel: catch pulse, status, time since catch and filtered level.
`timescale 1ns / 1ps
`default_nettype none

interface aczq_out_if;
    logic                  valid;
    logic                  ready;
    logic                  catch_pulse;
    logic [1:0]            status;
    aczq_pkg::count_t      time_since_catch;
    logic                  filtered_level;

    modport source (output valid, output catch_pulse, output status,
                    output time_since_catch, output filtered_level, input ready);
    modport sink   (input valid, input catch_pulse, input status,
                    input time_since_catch, input filtered_level, output ready);
endinterface

`default_nettype wire

// ===== hdl/ac_zero_cross_qualifier_core.sv =====
// An accepted item's result is loaded into the output register at the clock edge that accepts it.
// Throughput: one item per cycle; all state updates in the same cycle an item is accepted.
// The output register frees itself in the cycle its result is taken, so input stalls
// only while a result waits and the sink holds ready low.
// Reset (rst_n, asynchronous): status idle, counters and registers at their defaults,
// no result pending.
`timescale 1ns / 1ps
`default_nettype none

module ac_zero_cross_qualifier_core #(
    parameter int WINDOW_LEN = 5
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    aczq_in_if.sink          in_ch,
    aczq_out_if.source       out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int CNT_W = $clog2(WINDOW_LEN + 1);

    // Configuration registers
    aczq_pkg::count_t min_stable_reg, max_stable_reg, delay_rise_reg, delay_fall_reg;

    // Qualifier state
    logic [WINDOW_LEN-1:0] window_reg, window_next;
    logic                  level_reg, level_next;
    aczq_pkg::status_t     status_reg, status_next;
    aczq_pkg::count_t      stable_reg, stable_next;
    aczq_pkg::count_t      good_reg, good_next;
    aczq_pkg::count_t      bad_reg, bad_next;
    aczq_pkg::count_t      elapsed_reg, elapsed_next;
    aczq_pkg::count_t      delay_reg, delay_next;

    // Result register
    logic                  out_valid_reg, out_valid_next;
    logic                  pulse_reg, pulse_next;

    logic                  in_fire;
    logic                  cfg_write;
    aczq_pkg::reg_index_t  cfg_index;
    logic                  new_level;
    aczq_pkg::count_t      delay_sel;
    logic [WINDOW_LEN+aczq_pkg::BEGIN_WIDTH-1:0] begin_ext;

    function automatic logic majority(input logic [WINDOW_LEN-1:0] w);
        logic [CNT_W-1:0] ones;
        ones = '0;
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            ones = ones + CNT_W'(w[i]);
        end
        return (ones > CNT_W'(WINDOW_LEN / 2));
    endfunction

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = aczq_pkg::reg_index_t'(paddr[3:2]);

    always_comb
    begin
        unique case (cfg_index)
            aczq_pkg::REG_MIN_STABLE:    prdata = {24'd0, min_stable_reg};
            aczq_pkg::REG_MAX_STABLE:    prdata = {24'd0, max_stable_reg};
            aczq_pkg::REG_DELAY_RISING:  prdata = {24'd0, delay_rise_reg};
            aczq_pkg::REG_DELAY_FALLING: prdata = {24'd0, delay_fall_reg};
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_stable_reg <= aczq_pkg::MIN_STABLE_RESET;
            max_stable_reg <= aczq_pkg::MAX_STABLE_RESET;
            delay_rise_reg <= '0;
            delay_fall_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                aczq_pkg::REG_MIN_STABLE:    min_stable_reg <= pwdata[7:0];
                aczq_pkg::REG_MAX_STABLE:    max_stable_reg <= pwdata[7:0];
                aczq_pkg::REG_DELAY_RISING:  delay_rise_reg <= pwdata[7:0];
                aczq_pkg::REG_DELAY_FALLING: delay_fall_reg <= pwdata[7:0];
                default:                     ;
            endcase
        end
    end

    assign begin_ext = {{WINDOW_LEN{1'b0}}, in_ch.begin_window};
    assign new_level = majority({window_reg[WINDOW_LEN-2:0], in_ch.sample_bit});
    assign delay_sel = new_level ? delay_rise_reg : delay_fall_reg;

    // Next state for one item
    always_comb
    begin
        window_next  = window_reg;
        level_next   = level_reg;
        status_next  = status_reg;
        stable_next  = stable_reg;
        good_next    = good_reg;
        bad_next     = bad_reg;
        elapsed_next = elapsed_reg;
        delay_next   = delay_reg;
        pulse_next   = 1'b0;

        if (in_fire)
        begin
            if (in_ch.mode == aczq_pkg::MODE_BEGIN)
            begin
                window_next  = begin_ext[WINDOW_LEN-1:0];
                level_next   = majority(begin_ext[WINDOW_LEN-1:0]);
                status_next  = aczq_pkg::STATUS_CAL;
                elapsed_next = aczq_pkg::ELAPSED_SAT;
                good_next    = aczq_pkg::COUNT_FULL;
                bad_next     = aczq_pkg::COUNT_FULL;
            end
            else
            begin
                // A pending delayed catch fires when its count runs out.
                if (delay_reg != '0)
                begin
                    delay_next = delay_reg - 8'd1;
                    if (delay_next == '0)
                    begin
                        pulse_next   = 1'b1;
                        elapsed_next = aczq_pkg::COUNT_FULL;
                    end
                end
                if (elapsed_next != aczq_pkg::ELAPSED_SAT)
                begin
                    elapsed_next = elapsed_next + 8'd1;
                end

                if (status_reg != aczq_pkg::STATUS_IDLE)
                begin
                    window_next = {window_reg[WINDOW_LEN-2:0], in_ch.sample_bit};
                    if (new_level == level_reg)
                    begin
                        if (stable_reg < max_stable_reg)
                        begin
                            stable_next = stable_reg + 8'd1;
                        end
                        else
                        begin
                            // No edge inside the allowed interval counts as an error.
                            stable_next = '0;
                            good_next   = aczq_pkg::COUNT_FULL;
                            bad_next    = bad_reg - 8'd1;
                            if (bad_next == '0)
                            begin
                                status_next = aczq_pkg::STATUS_ERROR;
                            end
                        end
                    end
                    else
                    begin
                        level_next  = new_level;
                        stable_next = '0;
                        if (status_reg == aczq_pkg::STATUS_CAL)
                        begin
                            status_next = aczq_pkg::STATUS_READY;
                        end
                        else if (stable_reg > min_stable_reg)
                        begin
                            bad_next = aczq_pkg::COUNT_FULL;
                            if (status_reg == aczq_pkg::STATUS_READY)
                            begin
                                if (delay_sel == '0)
                                begin
                                    pulse_next   = 1'b1;
                                    elapsed_next = '0;
                                end
                                else
                                begin
                                    delay_next = delay_sel;
                                end
                            end
                            good_next = good_reg - 8'd1;
                            if (good_next == '0)
                            begin
                                status_next = aczq_pkg::STATUS_READY;
                            end
                        end
                        else
                        begin
                            good_next = aczq_pkg::COUNT_FULL;
                            bad_next  = bad_reg - 8'd1;
                            if (bad_next == '0)
                            begin
                                status_next = aczq_pkg::STATUS_ERROR;
                            end
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= '0;
            level_reg     <= 1'b0;
            status_reg    <= aczq_pkg::STATUS_IDLE;
            stable_reg    <= '0;
            good_reg      <= aczq_pkg::COUNT_FULL;
            bad_reg       <= aczq_pkg::COUNT_FULL;
            elapsed_reg   <= aczq_pkg::ELAPSED_SAT;
            delay_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            window_reg    <= window_next;
            level_reg     <= level_next;
            status_reg    <= status_next;
            stable_reg    <= stable_next;
            good_reg      <= good_next;
            bad_reg       <= bad_next;
            elapsed_reg   <= elapsed_next;
            delay_reg     <= delay_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The pulse flag is the only result field not already held in state.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pulse_reg <= pulse_next;
        end
    end

    // Outputs: status, time and level are read straight from the state registers,
    // which change only when the next item is accepted.
    always_comb
    begin
        out_ch.valid            = out_valid_reg;
        out_ch.catch_pulse      = pulse_reg;
        out_ch.status           = status_reg;
        out_ch.time_since_catch = elapsed_reg;
        out_ch.filtered_level   = level_reg;
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_ac_zero_cross_qualifier_core.sv =====
// Testbench for the AC zero-crossing qualifier: directed table, random waveforms, scoreboard.
`timescale 1ns / 1ps

module tb_ac_zero_cross_qualifier_core;

    typedef struct packed {
        logic                catch_pulse;
        aczq_pkg::status_t   status;
        aczq_pkg::count_t    time_since_catch;
        logic                filtered_level;
    } catch_result_t;

    typedef struct {
        aczq_pkg::mode_t mode;
        logic            sample_bit;
        logic [4:0]      begin_window;
        bit              typed;
        catch_result_t   want;
    } stim_row_t;

    localparam catch_result_t UNTYPED = '0;
    localparam int RETUNE_ROW = 6;
    localparam int NUM_ROWS = 23;

    // Rows 0..5 run with the reset settings; the rest run with a short stable window,
    // a rising delay of three ticks and an immediate falling catch.
    stim_row_t directed_rows [NUM_ROWS] = '{
        '{aczq_pkg::MODE_TICK, 1'b0, 5'd0, 1'b1,
          '{1'b0, aczq_pkg::STATUS_IDLE, 8'd254, 1'b0}},
        '{aczq_pkg::MODE_TICK, 1'b1, 5'd31, 1'b1,
          '{1'b0, aczq_pkg::STATUS_IDLE, 8'd254, 1'b0}},
        '{aczq_pkg::MODE_BEGIN, 1'b0, 5'd31, 1'b1,
          '{1'b0, aczq_pkg::STATUS_CAL, 8'd254, 1'b1}},
        '{aczq_pkg::MODE_BEGIN, 1'b1, 5'd0, 1'b1,
          '{1'b0, aczq_pkg::STATUS_CAL, 8'd254, 1'b0}},
        '{aczq_pkg::MODE_BEGIN, 1'b0, 5'b00111, 1'b1,
          '{1'b0, aczq_pkg::STATUS_CAL, 8'd254, 1'b1}},
        '{aczq_pkg::MODE_BEGIN, 1'b1, 5'b11000, 1'b1,
          '{1'b0, aczq_pkg::STATUS_CAL, 8'd254, 1'b0}},
        '{aczq_pkg::MODE_TICK, 1'b1, 5'd0, 1'b0, UNTYPED},
        '{aczq_pkg::MODE_TICK, 1'b1, 5'd0, 1'b0, UNTYPED},
        '{aczq_pkg::MODE_TICK, 1'b1, 5'd0, 1'b0, UNTYPED},
        '{aczq_pkg::MODE_TICK, 1'b0, 5'd0, 1'b0, UNTYPED},
        '{aczq_pkg::MODE_TICK, 1'b0, 5'd0, 1'b0, UNTYPED},
        '{aczq_pkg::MODE_TICK, 1'b0, 5'd0, 1'b0, UNTYPED},
        '{aczq_pkg::MODE_TICK, 1'b1, 5'd0, 1'b0, UNTYPED},
        '{aczq_pkg::MODE_TICK, 1'b1, 5'd0, 1'b0, UNTYPED},
        '{aczq_pkg::MODE_TICK, 1'b1, 5'd0, 1'b0, UNTYPED},
        '{aczq_pkg::MODE_TICK, 1'b0, 5'd0, 1'b0, UNTYPED},
        '{aczq_pkg::MODE_TICK, 1'b0, 5'd0, 1'b0, UNTYPED},
        // The delayed rising catch and the immediate falling catch land on this tick.
        '{aczq_pkg::MODE_TICK, 1'b0, 5'd0, 1'b0, UNTYPED},
        '{aczq_pkg::MODE_TICK, 1'b0, 5'd0, 1'b0, UNTYPED},
        '{aczq_pkg::MODE_TICK, 1'b0, 5'd0, 1'b0, UNTYPED},
        '{aczq_pkg::MODE_TICK, 1'b0, 5'd0, 1'b0, UNTYPED},
        '{aczq_pkg::MODE_TICK, 1'b0, 5'd0, 1'b0, UNTYPED},
        // Stable count has hit the maximum here, so this tick is a missing-edge error.
        '{aczq_pkg::MODE_TICK, 1'b0, 5'd0, 1'b0, UNTYPED}
    };

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    aczq_in_if  in_ch ();
    aczq_out_if out_ch ();

    ac_zero_cross_qualifier_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor copy of the registers and the qualifier state.
    aczq_pkg::count_t  cfg_min;
    aczq_pkg::count_t  cfg_max;
    aczq_pkg::count_t  cfg_rise;
    aczq_pkg::count_t  cfg_fall;
    logic [4:0]        win_q;
    logic              level_q;
    aczq_pkg::status_t status_q;
    aczq_pkg::count_t  stable_q;
    aczq_pkg::count_t  good_q;
    aczq_pkg::count_t  bad_q;
    aczq_pkg::count_t  elapsed_q;
    aczq_pkg::count_t  delay_q;

    catch_result_t pending_results [$];
    catch_result_t want_now;
    bit            steady;
    int            errors;
    int            n_items;
    int            n_results;
    int            n_pulses;
    int            n_ready;
    int            n_error;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic catch_result_t qualify_item(aczq_pkg::mode_t m, logic b,
                                                   logic [4:0] w);
        catch_result_t    r;
        logic             lvl;
        aczq_pkg::count_t d;
        r.catch_pulse = 1'b0;
        if (m == aczq_pkg::MODE_BEGIN)
        begin
            win_q = w;
            level_q = ($countones(w) > 2);
            status_q = aczq_pkg::STATUS_CAL;
            elapsed_q = aczq_pkg::ELAPSED_SAT;
            good_q = aczq_pkg::COUNT_FULL;
            bad_q = aczq_pkg::COUNT_FULL;
        end
        else
        begin
            if (delay_q != '0)
            begin
                delay_q = delay_q - 8'd1;
                if (delay_q == '0)
                begin
                    r.catch_pulse = 1'b1;
                    elapsed_q = aczq_pkg::COUNT_FULL;
                end
            end
            if (elapsed_q != aczq_pkg::ELAPSED_SAT)
                elapsed_q = elapsed_q + 8'd1;
            if (status_q != aczq_pkg::STATUS_IDLE)
            begin
                win_q = {win_q[3:0], b};
                lvl = ($countones(win_q) > 2);
                if (lvl == level_q)
                begin
                    if (stable_q < cfg_max)
                        stable_q = stable_q + 8'd1;
                    else
                    begin
                        stable_q = '0;
                        good_q = aczq_pkg::COUNT_FULL;
                        bad_q = bad_q - 8'd1;
                        if (bad_q == '0)
                            status_q = aczq_pkg::STATUS_ERROR;
                    end
                end
                else
                begin
                    level_q = lvl;
                    if (status_q == aczq_pkg::STATUS_CAL)
                        status_q = aczq_pkg::STATUS_READY;
                    else if (stable_q > cfg_min)
                    begin
                        bad_q = aczq_pkg::COUNT_FULL;
                        if (status_q == aczq_pkg::STATUS_READY)
                        begin
                            d = lvl ? cfg_rise : cfg_fall;
                            if (d == '0)
                            begin
                                r.catch_pulse = 1'b1;
                                elapsed_q = '0;
                            end
                            else
                                delay_q = d;
                        end
                        good_q = good_q - 8'd1;
                        if (good_q == '0)
                            status_q = aczq_pkg::STATUS_READY;
                    end
                    else
                    begin
                        good_q = aczq_pkg::COUNT_FULL;
                        bad_q = bad_q - 8'd1;
                        if (bad_q == '0)
                            status_q = aczq_pkg::STATUS_ERROR;
                    end
                    stable_q = '0;
                end
            end
        end
        r.status = status_q;
        r.time_since_catch = elapsed_q;
        r.filtered_level = level_q;
        return r;
    endfunction

    function automatic void check_field(string name, int want, int seen);
        if (want != seen)
        begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
        end
    endfunction

    // Result side: random back-pressure except in steady phases, checked against the oldest expectation.
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                n_results++;
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result arrived with none expected", $time);
                end
                else
                begin
                    want_now = pending_results.pop_front();
                    check_field("catch_pulse", want_now.catch_pulse, out_ch.catch_pulse);
                    check_field("status", int'(want_now.status), out_ch.status);
                    check_field("time_since_catch", want_now.time_since_catch,
                                out_ch.time_since_catch);
                    check_field("filtered_level", want_now.filtered_level,
                                out_ch.filtered_level);
                end
                n_pulses += out_ch.catch_pulse;
                n_ready += (out_ch.status == aczq_pkg::STATUS_READY);
                n_error += (out_ch.status == aczq_pkg::STATUS_ERROR);
            end
            out_ch.ready <= rst_n && (steady || $urandom_range(99) >= 11);
        end
    end

    task automatic send_item(aczq_pkg::mode_t m, logic b, logic [4:0] w, bit typed,
                             catch_result_t want);
        catch_result_t predicted;
        while (!steady && $urandom_range(99) < 11)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode <= m;
        in_ch.sample_bit <= b;
        in_ch.begin_window <= w;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predicted = qualify_item(m, b, w);
        pending_results.push_back(typed ? want : predicted);
        n_items++;
    endtask

    task automatic send_tick(logic b);
        send_item(aczq_pkg::MODE_TICK, b, 5'($urandom), 1'b0, UNTYPED);
    endtask

    task automatic send_begin();
        send_item(aczq_pkg::MODE_BEGIN, 1'($urandom), 5'($urandom), 1'b0, UNTYPED);
    endtask

    // Hold the input off until every expected result has been taken.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(aczq_pkg::reg_index_t idx, aczq_pkg::count_t v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            aczq_pkg::REG_MIN_STABLE:    cfg_min = v;
            aczq_pkg::REG_MAX_STABLE:    cfg_max = v;
            aczq_pkg::REG_DELAY_RISING:  cfg_rise = v;
            aczq_pkg::REG_DELAY_FALLING: cfg_fall = v;
        endcase
    endtask

    task automatic configure(aczq_pkg::count_t min_ticks, aczq_pkg::count_t max_ticks,
                             aczq_pkg::count_t rise, aczq_pkg::count_t fall);
        settle();
        write_reg(aczq_pkg::REG_MIN_STABLE, min_ticks);
        write_reg(aczq_pkg::REG_MAX_STABLE, max_ticks);
        write_reg(aczq_pkg::REG_DELAY_RISING, rise);
        write_reg(aczq_pkg::REG_DELAY_FALLING, fall);
    endtask

    // Square waves with random half periods; when noisy, also glitches, bursts of
    // random samples and the odd begin command.
    task automatic run_phase(int budget, int lo, int hi, bit noisy);
        int   stop;
        int   half;
        logic lvl;
        stop = n_items + budget;
        lvl = 1'($urandom);
        while (n_items < stop)
        begin
            if (noisy && $urandom_range(99) < 12)
            begin
                repeat ($urandom_range(5, 1))
                    send_tick(1'($urandom));
            end
            else if (noisy && $urandom_range(99) < 3)
                send_begin();
            else
            begin
                half = $urandom_range(hi, lo);
                repeat (half)
                    send_tick((noisy && $urandom_range(99) < 4) ? ~lvl : lvl);
                lvl = ~lvl;
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.mode <= aczq_pkg::MODE_TICK;
        in_ch.sample_bit <= 1'b0;
        in_ch.begin_window <= '0;
        steady = 1'b0;
        errors = 0;
        n_items = 0;
        n_results = 0;
        n_pulses = 0;
        n_ready = 0;
        n_error = 0;
        cfg_min = aczq_pkg::MIN_STABLE_RESET;
        cfg_max = aczq_pkg::MAX_STABLE_RESET;
        cfg_rise = '0;
        cfg_fall = '0;
        win_q = '0;
        level_q = 1'b0;
        status_q = aczq_pkg::STATUS_IDLE;
        stable_q = '0;
        good_q = aczq_pkg::COUNT_FULL;
        bad_q = aczq_pkg::COUNT_FULL;
        elapsed_q = aczq_pkg::ELAPSED_SAT;
        delay_q = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            if (i == RETUNE_ROW)
                configure(8'd1, 8'd4, 8'd3, 8'd0);
            send_item(directed_rows[i].mode, directed_rows[i].sample_bit,
                      directed_rows[i].begin_window, directed_rows[i].typed,
                      directed_rows[i].want);
        end

        configure(8'd3, 8'd9, 8'd0, 8'd0);
        send_begin();
        run_phase(70, 4, 10, 1'b1);
        settle();
        run_phase(70, 4, 10, 1'b1);

        configure(8'd2, 8'd10, 8'($urandom_range(8, 1)), 8'($urandom_range(8, 1)));
        steady = 1'b1;
        send_begin();
        run_phase(120, 3, 11, 1'b1);
        steady = 1'b0;

        // Every tick is an error here, driving the block into AC error and wrapping
        // the error counter.
        configure(8'd0, 8'd0, 8'd0, 8'd0);
        run_phase(270, 1, 6, 1'b0);

        configure(8'd255, 8'd255, 8'd255, 8'd255);
        send_begin();
        run_phase(40, 1, 8, 1'b1);

        configure(8'd4, 8'd12, 8'($urandom_range(15, 0)), 8'($urandom_range(15, 0)));
        send_begin();
        run_phase(100, 4, 14, 1'b1);

        settle();
        repeat (10) @(posedge clk);
        $display("%0d items sent, %0d results compared, %0d catch pulses seen",
                 n_items, n_results, n_pulses);
        $display("results while ready: %0d, while in AC error: %0d", n_ready, n_error);
        if (errors == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
